### sv/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg
// Shared types and constants of the Mahalanobis anomaly detector.
// ----------------------------------------------------------------------------
package mad_pkg;

   localparam int DIM      = 5;
   localparam int IDX_W    = 3;
   localparam int FEAT_W   = 16;
   localparam int DIFF_W   = 17;
   localparam int ACC_W    = 36;
   localparam int ACC_LO_W = 18;
   localparam int ACC_HI_W = ACC_W - ACC_LO_W;
   localparam int TERM_W   = 54;
   localparam int Q_W      = 57;
   localparam int FRAC_DROP = 12;
   localparam int RAD_W    = 44;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 4;
   localparam int STEP_W   = 5;
   localparam int UPD_W    = 34;
   localparam logic [FEAT_W-1:0] COEF_ONE = 16'sd4096;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SCORE  = 2'd1,
      MODE_UPDATE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      REG_THRESHOLD  = 1'b0,
      REG_EMA_WEIGHT = 1'b1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_QLO,
      ST_QHI,
      ST_SUM,
      ST_SQRT,
      ST_DONE,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_col;
      logic             clr;
      logic             mac;
      logic             qlo;
      logic             qhi;
      logic             umul;
      logic             uwr;
   } lane_ctrl_type;

endpackage

### sv/mad_if.sv
// ----------------------------------------------------------------------------
// mad_req_if / mad_rsp_if
// Valid/ready channels for input vectors and distance results.
// ----------------------------------------------------------------------------
interface mad_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [2:0]        coef_row;
   logic [2:0]        coef_col;
   logic signed [15:0] coef_value;
   logic signed [15:0] feature_0;
   logic signed [15:0] feature_1;
   logic signed [15:0] feature_2;
   logic signed [15:0] feature_3;
   logic signed [15:0] feature_4;

   modport source (output valid, mode, coef_row, coef_col, coef_value,
                   feature_0, feature_1, feature_2, feature_3, feature_4,
                   input ready);
   modport sink   (input valid, mode, coef_row, coef_col, coef_value,
                   feature_0, feature_1, feature_2, feature_3, feature_4,
                   output ready);
endinterface

interface mad_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] distance;
   logic        anomaly;

   modport source (output valid, distance, anomaly, input ready);
   modport sink   (input valid, distance, anomaly, output ready);
endinterface

### sv/mad_isqrt.sv
// ----------------------------------------------------------------------------
// mad_isqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mad_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mad_pkg::RAD_W-1:0]   radicand,
   output logic                        done,
   output logic [mad_pkg::ROOT_W-1:0]  root
);
   import mad_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = STEP_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down two radicand bits, try the next root bit
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### sv/mad_lane.sv
// ----------------------------------------------------------------------------
// mad_lane
// One matrix row: holds the row coefficients and one mean element, forms the
// row product with the difference vector, this element's quadratic term and the mean update.
// ----------------------------------------------------------------------------
module mad_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mad_pkg::IDX_W-1:0]          lane_id,
   input  mad_pkg::lane_ctrl_type             ctrl,
   input  logic signed [mad_pkg::FEAT_W-1:0]  load_value,
   input  logic signed [mad_pkg::DIFF_W-1:0]  diff_col,
   input  logic signed [mad_pkg::DIFF_W-1:0]  diff_own,
   input  logic [15:0]                        ema_weight,
   output logic signed [mad_pkg::FEAT_W-1:0]  mean,
   output logic signed [mad_pkg::TERM_W-1:0]  term
);
   import mad_pkg::*;

   logic signed [FEAT_W-1:0] row_ff [DIM];
   logic signed [FEAT_W-1:0] mean_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  lo_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [UPD_W-1:0]  upd_ff;
   logic signed [ACC_W-1:0]  mac_prod;
   logic signed [ACC_W-1:0]  lo_prod;
   logic signed [ACC_W-1:0]  hi_prod;
   logic signed [UPD_W-1:0]  upd_rnd;

   always_comb begin
      mac_prod = ACC_W'(row_ff[ctrl.load_col] * diff_col);
      lo_prod  = $signed({1'b0, acc_ff[ACC_LO_W-1:0]}) * diff_own;
      hi_prod  = ACC_W'($signed(acc_ff[ACC_W-1:ACC_LO_W]) * diff_own);
      upd_rnd  = upd_ff + UPD_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < DIM; c++) begin
            row_ff[c] <= (IDX_W'(c) == lane_id) ? COEF_ONE : '0;
         end
         mean_ff <= '0;
      end else begin
         if (ctrl.load) begin
            row_ff[ctrl.load_col] <= load_value;
         end
         if (ctrl.uwr) begin
            mean_ff <= mean_ff + upd_rnd[FEAT_W+15:16];
         end
      end
      if (ctrl.clr) begin
         acc_ff <= '0;
      end else if (ctrl.mac) begin
         acc_ff <= acc_ff + mac_prod;
      end
      if (ctrl.qlo) begin
         lo_ff <= lo_prod;
      end
      if (ctrl.qhi) begin
         term_ff <= TERM_W'({hi_prod, {ACC_LO_W{1'b0}}}) + TERM_W'(lo_ff);
      end
      if (ctrl.umul) begin
         upd_ff <= diff_own * $signed({1'b0, ema_weight});
      end
   end

   assign mean = mean_ff;
   assign term = term_ff;

endmodule

### sv/mahalanobis_anomaly_detector.sv
// ----------------------------------------------------------------------------
// mahalanobis_anomaly_detector
// Scores feature vectors by Mahalanobis distance against a running mean.
// ----------------------------------------------------------------------------
// Sequence: a score runs the MAC steps, the low and high term steps, the merge,
//   the 22-step square root and the output register; an update multiplies,
//   then writes the mean; a load finishes at the transfer. One vector at a
//   time: a score holds off transfers until its result is registered.
// Reset (synchronous): mean zero, precision matrix identity, threshold 768,
//   EMA weight 655, no result pending.
module mahalanobis_anomaly_detector (
   input  logic        clock,
   input  logic        reset,
   mad_req_if.sink     req_ch,
   mad_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mad_pkg::*;

   // configuration registers
   logic [15:0] thresh_ff, weight_ff;
   logic        csr_wr;
   reg_idx_type csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = reg_idx_type'(paddr[2]);

   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD:  prdata = {16'd0, thresh_ff};
         REG_EMA_WEIGHT: prdata = {16'd0, weight_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 16'd768;
         weight_ff <= 16'd655;
      end else if (csr_wr) begin
         if (csr_idx == REG_THRESHOLD) thresh_ff <= pwdata[15:0];
         if (csr_idx == REG_EMA_WEIGHT) weight_ff <= pwdata[15:0];
      end
   end

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   mode_type         req_mode;
   logic signed [FEAT_W-1:0] feat [DIM];
   logic signed [FEAT_W-1:0] lane_mean [DIM];
   logic signed [TERM_W-1:0] lane_term [DIM];
   logic signed [DIFF_W-1:0] diff_ff [DIM];
   lane_ctrl_type    ctrl [DIM];
   lane_ctrl_type    base_ctrl;
   logic             load_ok;
   logic signed [Q_W-1:0] q_sum;
   logic [RAD_W-1:0] rad_ff;
   logic             sqrt_done;
   logic [ROOT_W-1:0] root;
   logic             out_free;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      dist_ff;
   logic             anom_ff;

   assign req_mode = mode_type'(req_ch.mode);
   assign accept   = req_ch.valid & req_ch.ready;
   assign feat[0]  = req_ch.feature_0;
   assign feat[1]  = req_ch.feature_1;
   assign feat[2]  = req_ch.feature_2;
   assign feat[3]  = req_ch.feature_3;
   assign feat[4]  = req_ch.feature_4;
   assign load_ok  = (req_ch.coef_row < IDX_W'(DIM)) && (req_ch.coef_col < IDX_W'(DIM));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               priority if (req_mode == MODE_SCORE) begin
                  state_in = ST_MAC;
                  cnt_in   = '0;
               end else if (req_mode == MODE_UPDATE) begin
                  state_in = ST_UPD;
               end else begin
                  // load and the unused mode finish at the transfer
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(DIM - 1)) state_in = ST_QLO;
         end
         ST_QLO:  state_in = ST_QHI;
         ST_QHI:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_SQRT;
         ST_SQRT: if (sqrt_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         ST_UPD: begin
            // multiply first, then write the mean
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && req_ch.valid && req_mode == MODE_UPDATE) cnt_in = '0;
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      base_ctrl    = '0;
      base_ctrl.load_col = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            base_ctrl.clr      = 1'b1;
            base_ctrl.load_col = req_ch.coef_col;
         end
         ST_MAC:  base_ctrl.mac  = 1'b1;
         ST_QLO:  base_ctrl.qlo  = 1'b1;
         ST_QHI:  base_ctrl.qhi  = 1'b1;
         ST_SUM:  ;
         ST_SQRT: ;
         ST_DONE: ;
         ST_UPD: begin
            base_ctrl.umul = (cnt_ff == '0);
            base_ctrl.uwr  = (cnt_ff != '0);
         end
         default: ;
      endcase
      for (int i = 0; i < DIM; i++) begin
         ctrl[i]      = base_ctrl;
         ctrl[i].load = accept && req_mode == MODE_LOAD && load_ok
                        && req_ch.coef_row == IDX_W'(i);
      end
   end

   // difference vector, captured at each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < DIM; i++) begin
            diff_ff[i] <= DIFF_W'(feat[i]) - DIFF_W'(lane_mean[i]);
         end
      end
   end

   for (genvar g = 0; g < DIM; g++) begin : g_lane
      mad_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_id    (IDX_W'(g)),
         .ctrl       (ctrl[g]),
         .load_value (req_ch.coef_value),
         .diff_col   (diff_ff[cnt_ff]),
         .diff_own   (diff_ff[g]),
         .ema_weight (weight_ff),
         .mean       (lane_mean[g]),
         .term       (lane_term[g])
      );
   end

   // merge the lane terms; drop the fraction, a non-positive form gives zero
   always_comb begin
      q_sum = '0;
      for (int i = 0; i < DIM; i++) begin
         q_sum = q_sum + Q_W'(lane_term[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         rad_ff <= (q_sum > 0) ? q_sum[FRAC_DROP +: RAD_W] : '0;
      end
   end

   logic sum_dly_ff;
   always_ff @(posedge clock) begin
      if (reset) sum_dly_ff <= 1'b0;
      else       sum_dly_ff <= (state_ff == ST_SUM);
   end

   mad_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sum_dly_ff),
      .radicand (rad_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // result register, parted from the sequencer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE && out_free) rsp_valid_in = 1'b1;
   end

   logic [ROOT_W-1:0] root_hold_ff;
   always_ff @(posedge clock) begin
      if (sqrt_done) root_hold_ff <= root;
      if (state_ff == ST_DONE && out_free) begin
         dist_ff <= (root_hold_ff > ROOT_W'(16'hFFFF)) ? 16'hFFFF : root_hold_ff[15:0];
         anom_ff <= root_hold_ff > ROOT_W'(thresh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = dist_ff;
   assign rsp_ch.anomaly  = anom_ff;

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_root_in_sqrt: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_SQRT) else $error("root finished out of turn");
   a_anom_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.anomaly |-> rsp_ch.distance != 16'd0)
      else $error("anomaly with zero distance");
   a_done_after_sqrt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> $past(state_ff) == ST_SQRT || $past(state_ff) == ST_DONE)
      else $error("result stage entered out of order");

endmodule

### tb/mad_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mad_score_checker
// Watches the vector and result channels, keeps its own copy of the mean,
// precision matrix and registers, predicts each score and compares it.
// ----------------------------------------------------------------------------
module mad_score_checker (
   input  logic        clock,
   input  logic        reset,
   mad_req_if.sink     req_mon,
   mad_rsp_if.sink     rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          scores_pending
);
   import mad_pkg::*;

   typedef struct packed {
      logic [15:0] distance;
      logic        anomaly;
   } score_type;

   logic [15:0]        threshold_q;
   logic [15:0]        alpha_q;
   logic signed [15:0] mean_q [DIM];
   logic signed [15:0] prec_q [DIM*DIM];
   score_type          score_fifo [$];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic score_type predict_score(input logic signed [15:0] x [DIM]);
      longint    dlt [DIM];
      longint    q;
      longint    acc;
      logic [63:0] root;
      score_type s;
      q = 0;
      for (int i = 0; i < DIM; i++) dlt[i] = longint'(x[i]) - longint'(mean_q[i]);
      for (int i = 0; i < DIM; i++) begin
         acc = 0;
         for (int j = 0; j < DIM; j++) acc += longint'(prec_q[i*DIM+j]) * dlt[j];
         q += acc * dlt[i];
      end
      root = (q > 0) ? int_sqrt(64'(q) >> FRAC_DROP) : 64'd0;
      s.distance = (root > 65535) ? 16'hFFFF : root[15:0];
      s.anomaly  = root > {48'd0, threshold_q};
      return s;
   endfunction

   always @(posedge clock) begin
      logic signed [15:0] x [DIM];
      longint             w, acc;
      score_type          got, want;
      int                 errs;
      errs = 0;
      if (reset) begin
         threshold_q = 16'd768;
         alpha_q     = 16'd655;
         for (int i = 0; i < DIM; i++) mean_q[i] = '0;
         for (int i = 0; i < DIM*DIM; i++) prec_q[i] = (i % (DIM+1) == 0) ? COEF_ONE : '0;
         score_fifo.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_THRESHOLD) threshold_q = pwdata[15:0];
            else                           alpha_q     = pwdata[15:0];
         end
         // compare the oldest expectation before new ones land
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.distance = rsp_mon.distance;
            got.anomaly  = rsp_mon.anomaly;
            if (score_fifo.size() == 0) begin
               $error("unexpected result distance %0d anomaly %0d",
                      got.distance, got.anomaly);
               errs++;
            end else begin
               want = score_fifo.pop_front();
               if (got.distance !== want.distance) begin
                  $error("distance: expected %0d actual %0d", want.distance, got.distance);
                  errs++;
               end
               if (got.anomaly !== want.anomaly) begin
                  $error("anomaly: expected %0d actual %0d", want.anomaly, got.anomaly);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            x = '{req_mon.feature_0, req_mon.feature_1, req_mon.feature_2,
                  req_mon.feature_3, req_mon.feature_4};
            case (mode_type'(req_mon.mode))
               MODE_LOAD: begin
                  if (req_mon.coef_row < DIM && req_mon.coef_col < DIM)
                     prec_q[req_mon.coef_row*DIM + req_mon.coef_col] = req_mon.coef_value;
               end
               MODE_SCORE: score_fifo.push_back(predict_score(x));
               MODE_UPDATE: begin
                  w = longint'(alpha_q);
                  for (int i = 0; i < DIM; i++) begin
                     acc = (65536 - w) * longint'(mean_q[i]) + w * longint'(x[i]) + 32768;
                     mean_q[i] = 16'(acc >>> 16);
                  end
               end
               default: ;
            endcase
         end
         fail_count <= fail_count + errs;
      end
      scores_pending <= score_fifo.size();
   end

endmodule

### tb/tb_mahalanobis_anomaly_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mahalanobis_anomaly_detector
// Drives loads, scores and mean updates with random bursts and result stalls
// across several threshold and EMA weight settings; a checker predicts scores.
// ----------------------------------------------------------------------------
module tb_mahalanobis_anomaly_detector;
   import mad_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          scores_pending;
   int          cycle_count;
   logic        stall_mode;

   mad_req_if req_ch ();
   mad_rsp_if rsp_ch ();

   mahalanobis_anomaly_detector dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   mad_score_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
      .scores_pending(scores_pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Give up on a hang rather than spin forever.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_mahalanobis_anomaly_detector: errors");
            $finish;
         end
      end
   end

   // Stall the result side: alternate between always-ready stretches and
   // random back-pressure so both regimes are covered.
   initial begin
      rsp_ch.ready = 1'b0;
      stall_mode   = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
         rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Write one register: setup phase then access phase.
   task automatic write_reg(input reg_idx_type idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Hold until every score has returned, then let a load or update finish.
   task automatic drain();
      @(posedge clock);
      while (scores_pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Offer one vector and hold it until the transfer happens.
   task automatic send_vector(input mode_type m, input logic [2:0] row,
                              input logic [2:0] col, input logic [15:0] cv,
                              input logic [15:0] f [DIM]);
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= m;
      req_ch.coef_row   <= row;
      req_ch.coef_col   <= col;
      req_ch.coef_value <= cv;
      req_ch.feature_0  <= f[0];
      req_ch.feature_1  <= f[1];
      req_ch.feature_2  <= f[2];
      req_ch.feature_3  <= f[3];
      req_ch.feature_4  <= f[4];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_req();
      req_ch.valid <= 1'b0;
   endtask

   // Features either full-range or near zero, so the distance lands both
   // in and beyond the saturation limit.
   task automatic rand_features(output logic [15:0] f [DIM]);
      logic wide;
      wide = $urandom_range(0, 2) == 0;
      for (int i = 0; i < DIM; i++)
         f[i] = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 2047)) - 1024);
   endtask

   task automatic rand_vector();
      logic [15:0] f [DIM];
      int          pick;
      mode_type    m;
      logic [15:0] cv;
      rand_features(f);
      pick = $urandom_range(0, 99);
      m  = pick < 55 ? MODE_SCORE : pick < 75 ? MODE_UPDATE : pick < 96 ? MODE_LOAD : MODE_NONE;
      // mostly small coefficients keep q positive-definite-ish; some full range
      cv = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(0, 8191)) - 4096);
      send_vector(m, 3'($urandom_range(0, 7) < 6 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
                  3'($urandom_range(0, 7) < 6 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
                  cv, f);
   endtask

   initial begin
      logic [15:0] f [DIM];
      logic [15:0] thr_set [4];
      logic [15:0] ema_set [4];
      int          gap;

      thr_set = '{16'd0, 16'hFFFF, 16'd768, 16'd300};
      ema_set = '{16'hFFFF, 16'd0, 16'd655, 16'd32768};
      reset   = 1'b1;
      psel    = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      req_ch.valid = 0; req_ch.mode = 0; req_ch.coef_row = 0; req_ch.coef_col = 0;
      req_ch.coef_value = 0; req_ch.feature_0 = 0; req_ch.feature_1 = 0;
      req_ch.feature_2 = 0; req_ch.feature_3 = 0; req_ch.feature_4 = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity scores at the field extremes, zero vector and either side of the threshold.
      f = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      send_vector(MODE_SCORE, 0, 0, 0, f);
      f = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      send_vector(MODE_SCORE, 0, 0, 0, f);
      f = '{16'h0300, 16'd0, 16'd0, 16'd0, 16'd0};
      send_vector(MODE_SCORE, 0, 0, 0, f);
      f = '{16'h0301, 16'd0, 16'd0, 16'd0, 16'd0};
      send_vector(MODE_SCORE, 0, 0, 0, f);
      // Negative diagonal gives a negative quadratic form.
      send_vector(MODE_LOAD, 0, 0, 16'h8000, f);
      send_vector(MODE_SCORE, 0, 0, 0, f);
      // Out-of-range position is ignored; so is the unused mode.
      send_vector(MODE_LOAD, 5, 0, 16'h7FFF, f);
      send_vector(MODE_LOAD, 0, 7, 16'h7FFF, f);
      send_vector(MODE_NONE, 7, 7, 16'hFFFF, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_vector(MODE_LOAD, 4, 4, 16'h7FFF, f);
      send_vector(MODE_LOAD, 0, 0, COEF_ONE, f);
      send_vector(MODE_SCORE, 0, 0, 0, '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      send_vector(MODE_UPDATE, 0, 0, 0, '{16'h7FFF, 16'h8000, 16'h1234, 16'hFEDC, 16'h0001});
      send_vector(MODE_SCORE, 0, 0, 0, f);
      idle_req();
      drain();

      // Random phases, one register setting each, extremes included.
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_THRESHOLD, thr_set[phase]);
         write_reg(REG_EMA_WEIGHT, ema_set[phase]);
         for (int n = 0; n < 240; n++) begin
            rand_vector();
            if ($urandom_range(0, 3) == 0) begin
               idle_req();
               gap = $urandom_range(1, 20);
               repeat (gap) @(posedge clock);
            end
            // pause with nothing outstanding halfway through each phase
            if (n == 120) begin
               idle_req();
               drain();
            end
         end
         idle_req();
         drain();
      end

      if (fail_count == 0)
         $display("tb_mahalanobis_anomaly_detector: clean");
      else
         $display("tb_mahalanobis_anomaly_detector: errors");
      $finish;
   end

endmodule
